@@ hdl/wavetable_tone_generator_macros.svh @@
// Assertion macros shared by the checker of the tone generator.
`ifndef WAVETABLE_TONE_GENERATOR_MACROS_SVH
`define WAVETABLE_TONE_GENERATOR_MACROS_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define WTG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold at the clock edge after the antecedent.
`define WTG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/wtg_pkg.sv @@
package wtg_pkg;

   localparam int PHASE_BITS    = 16;
   localparam int STEP_BITS     = 16;
   localparam int SAMPLE_BITS   = 8;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] CSR_WAVE_SELECT  = 2'd0;
   localparam logic [1:0] CSR_PHASE_STEP   = 2'd1;
   localparam logic [1:0] CSR_SOUND_ENABLE = 2'd2;

   localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = STEP_BITS'(100);

   typedef enum logic [1:0] {
      WAVE_SQUARE   = 2'd0,
      WAVE_SINE     = 2'd1,
      WAVE_SAW      = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   localparam logic [SAMPLE_BITS-1:0] SINE_ROM [256] = '{
      8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
      8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
      8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
      8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
      8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
      8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245,
      8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252,
      8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254,
      8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
      8'd246, 8'd245, 8'd243, 8'd242, 8'd240, 8'd239, 8'd237, 8'd236,
      8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
      8'd218, 8'd216, 8'd213, 8'd211, 8'd209, 8'd206, 8'd204, 8'd201,
      8'd199, 8'd196, 8'd193, 8'd191, 8'd188, 8'd185, 8'd182, 8'd179,
      8'd176, 8'd174, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159, 8'd156,
      8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
      8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
      8'd103, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
      8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
      8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
      8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
      8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
      8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
      8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
      8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
      8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
      8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
      8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
      8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
      8'd79,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
      8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
   };

endpackage

@@ hdl/wtg_wave_shaper.sv @@
module wtg_wave_shaper (
   input  wtg_pkg::wave_type                  wave_select,
   input  logic [wtg_pkg::SAMPLE_BITS-1:0]    index,
   output logic [wtg_pkg::SAMPLE_BITS-1:0]    sample
);

   logic [wtg_pkg::SAMPLE_BITS-1:0] doubled;

   // Twice the index within its half cycle; the falling half of the
   // triangle is the bitwise complement of this.
   assign doubled = {index[wtg_pkg::SAMPLE_BITS-2:0], 1'b0};

   always_comb begin
      case (wave_select)
         wtg_pkg::WAVE_SQUARE: begin
            sample = index[wtg_pkg::SAMPLE_BITS-1] ? '0 : '1;
         end
         wtg_pkg::WAVE_SINE: begin
            sample = wtg_pkg::SINE_ROM[index];
         end
         wtg_pkg::WAVE_SAW: begin
            sample = index;
         end
         wtg_pkg::WAVE_TRIANGLE: begin
            sample = index[wtg_pkg::SAMPLE_BITS-1] ? ~doubled : doubled;
         end
         default: begin
            sample = '0;
         end
      endcase
   end

endmodule

@@ hdl/wavetable_tone_generator.sv @@
// Tone source by direct digital synthesis. Each accepted transaction with tick high,
// while sound is enabled, yields one 8-bit duty sample taken from the top eight
// bits of the phase accumulator through the selected waveform (square, sine,
// sawtooth, triangle); the phase step is then added with wrap. With tick low or
// sound disabled the transaction yields nothing and the phase holds. A transaction
// can be accepted in every cycle; the input stalls only while one sample waits in
// the lookup register behind a stalled sample in the output register. A sample reaches
// the output through the lookup register, which holds the table index, and then the
// output register, which holds the looked-up sample.
// Registers: 0x0 wave_select, 0x4 phase_step, 0x8 sound_enable; write them only
// while no transaction is in flight.
module wavetable_tone_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_tick,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wtg_pkg::SAMPLE_BITS-1:0]      rsp_sample,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wtg_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [wtg_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [wtg_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   wtg_pkg::wave_type                  wave_select_ff, wave_select_in;
   logic [wtg_pkg::STEP_BITS-1:0]      phase_step_ff, phase_step_in;
   logic                               sound_enable_ff, sound_enable_in;
   logic [wtg_pkg::PHASE_BITS-1:0]     phase_acc_ff, phase_acc_in;
   logic                               lookup_valid_ff, lookup_valid_in;
   logic [wtg_pkg::SAMPLE_BITS-1:0]    lookup_index_ff, lookup_index_in;
   logic                               out_valid_ff, out_valid_in;
   logic [wtg_pkg::SAMPLE_BITS-1:0]    out_sample_ff, out_sample_in;

   logic                               csr_write;
   logic [1:0]                         csr_index;
   logic                               req_accept;
   logic                               make_sample;
   logic                               out_advance;
   logic [wtg_pkg::SAMPLE_BITS-1:0]    shaped_sample;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[wtg_pkg::CSR_ADDR_BITS-1:2];

   always_comb begin
      wave_select_in  = wave_select_ff;
      phase_step_in   = phase_step_ff;
      sound_enable_in = sound_enable_ff;
      if (csr_write) begin
         case (csr_index)
            wtg_pkg::CSR_WAVE_SELECT: begin
               wave_select_in = wtg_pkg::wave_type'(csr_pwdata[1:0]);
            end
            wtg_pkg::CSR_PHASE_STEP: begin
               phase_step_in = csr_pwdata[wtg_pkg::STEP_BITS-1:0];
            end
            wtg_pkg::CSR_SOUND_ENABLE: begin
               sound_enable_in = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         wtg_pkg::CSR_WAVE_SELECT: begin
            csr_prdata = wtg_pkg::CSR_DATA_BITS'(wave_select_ff);
         end
         wtg_pkg::CSR_PHASE_STEP: begin
            csr_prdata = wtg_pkg::CSR_DATA_BITS'(phase_step_ff);
         end
         wtg_pkg::CSR_SOUND_ENABLE: begin
            csr_prdata = wtg_pkg::CSR_DATA_BITS'(sound_enable_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // The output register frees up when it is empty or being taken; the lookup
   // stage moves along with it, so the input only stalls behind a stalled result.
   assign out_advance = !out_valid_ff || !rsp_stall;
   assign req_stall   = lookup_valid_ff && !out_advance;
   assign req_accept  = req_valid && !req_stall;
   assign make_sample = req_accept && req_tick && sound_enable_ff;

   always_comb begin
      phase_acc_in    = phase_acc_ff;
      lookup_valid_in = lookup_valid_ff;
      lookup_index_in = lookup_index_ff;
      if (out_advance) begin
         lookup_valid_in = 1'b0;
      end
      if (make_sample) begin
         lookup_valid_in = 1'b1;
         lookup_index_in = phase_acc_ff[wtg_pkg::PHASE_BITS-1 -: wtg_pkg::SAMPLE_BITS];
         phase_acc_in    = phase_acc_ff + wtg_pkg::PHASE_BITS'(phase_step_ff);
      end
   end

   wtg_wave_shaper u_wave_shaper (
      .wave_select (wave_select_ff),
      .index       (lookup_index_ff),
      .sample      (shaped_sample)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      if (out_advance) begin
         out_valid_in  = lookup_valid_ff;
         out_sample_in = shaped_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_select_ff  <= wtg_pkg::WAVE_SQUARE;
         phase_step_ff   <= wtg_pkg::PHASE_STEP_RESET;
         sound_enable_ff <= 1'b1;
         phase_acc_ff    <= '0;
         lookup_valid_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         wave_select_ff  <= wave_select_in;
         phase_step_ff   <= phase_step_in;
         sound_enable_ff <= sound_enable_in;
         phase_acc_ff    <= phase_acc_in;
         lookup_valid_ff <= lookup_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lookup_index_ff <= lookup_index_in;
      out_sample_ff   <= out_sample_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;

endmodule

@@ hdl/wtg_checker.sv @@
`include "wavetable_tone_generator_macros.svh"

module wtg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_tick,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [wtg_pkg::SAMPLE_BITS-1:0]      rsp_sample,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [wtg_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input logic [wtg_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   input logic [wtg_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   input logic                                 csr_pready
);

   // A stalled sample must be held until it is taken.
   `WTG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample))

   // The input only stalls when a finished sample is waiting on a stalled output.
   `WTG_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // A sample on an idle output stems from a transaction via the lookup and output registers.
   `WTG_ASSERT_IMP(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && req_tick, 2))

   // The configuration port never inserts wait states.
   `WTG_ASSERT_IMP(a_csr_ready, clock, reset, csr_psel && csr_penable, csr_pready)

endmodule

bind wavetable_tone_generator wtg_checker u_wtg_checker (.*);
